@@ hdl/csc_pkg.sv @@
// Shared types and constants for the same-mode convolution block.
package csc_pkg;

  localparam int unsigned SAMPLE_BITS   = 16;  // input sample width
  localparam int unsigned TAP_W         = 16;  // Q4.12 coefficient width
  localparam int unsigned FRAC_BITS     = 12;  // fraction bits of a tap
  localparam int unsigned RESULT_W      = 32;  // result width
  localparam int unsigned KS_W          = 3;   // kernel_size register width
  localparam int unsigned NUM_TAP_REGS  = 7;   // tap registers on the config port
  localparam int unsigned CFG_IDX_W     = 3;   // register index width
  localparam int unsigned CFG_DATA_W    = 16;  // widest register
  localparam int unsigned MAX_TAPS_DEF  = 7;   // default window depth
  localparam int unsigned QUEUE_DEPTH   = 2;   // front-to-back queue entries

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP0        = 3'd1;

  localparam logic [KS_W-1:0] KERNEL_SIZE_RST = 3'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic                       result_last;
  } out_t;

  // Effective kernel size and its center offset
  typedef struct packed {
    logic [KS_W-1:0] k;
    logic [KS_W-1:0] c;
  } kern_t;

  // Head of the input queue as seen by the back end
  typedef struct packed {
    logic vld;
    in_t  item;
  } head_t;

endpackage

@@ hdl/csc_front.sv @@
// Front end: config registers, kernel size clamp and the input sample queue.
module csc_front #(
  parameter int unsigned MAX_TAPS = csc_pkg::MAX_TAPS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [csc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [csc_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  csc_pkg::in_t                           in_data_i,
  output csc_pkg::kern_t                         kern_o,
  output logic signed [csc_pkg::TAP_W-1:0]       taps_o [MAX_TAPS],
  output csc_pkg::head_t                         head_o,
  input  logic                                   pop_i
);
  import csc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KMAX  = (MAX_TAPS > NUM_TAP_REGS) ? NUM_TAP_REGS : MAX_TAPS;

  logic [KS_W-1:0]         ksize_q;
  logic signed [TAP_W-1:0] taps_q [MAX_TAPS];
  logic [KS_W-1:0]         k_eff;

  in_t              queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= KERNEL_SIZE_RST;
      for (int i = 0; i < MAX_TAPS; i++) begin
        taps_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_KERNEL_SIZE) begin
        ksize_q <= cfg_data_i[KS_W-1:0];
      end
      for (int i = 0; i < MAX_TAPS; i++) begin
        if ((i < NUM_TAP_REGS) && (int'(cfg_idx_i) == int'(REG_TAP0) + i)) begin
          taps_q[i] <= signed'(cfg_data_i[TAP_W-1:0]);
        end
      end
    end
  end

  // Zero means one tap; clamp to the window depth
  always_comb begin
    if (ksize_q == '0) begin
      k_eff = KS_W'(1);
    end else if (int'(ksize_q) > int'(KMAX)) begin
      k_eff = KS_W'(KMAX);
    end else begin
      k_eff = ksize_q;
    end
    kern_o.k = k_eff;
    kern_o.c = k_eff >> 1;
  end

  assign taps_o = taps_q;

  // Input queue
  assign in_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= in_data_i;
    end
  end

  assign head_o.vld  = (cnt_q != '0);
  assign head_o.item = queue_q[rd_ptr_q];

endmodule

@@ hdl/csc_back.sv @@
// Back end: window shift, flush sequencing, tap products and output register.
module csc_back #(
  parameter int unsigned MAX_TAPS = csc_pkg::MAX_TAPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  csc_pkg::kern_t                   kern_i,
  input  logic signed [csc_pkg::TAP_W-1:0] taps_i [MAX_TAPS],
  input  csc_pkg::head_t                   head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output csc_pkg::out_t                    out_data_o
);
  import csc_pkg::*;

  localparam int unsigned KMAX = (MAX_TAPS > NUM_TAP_REGS) ? NUM_TAP_REGS : MAX_TAPS;
  localparam int unsigned CMAX = KMAX / 2;
  localparam int unsigned LW   = (CMAX > 0) ? $clog2(CMAX + 1) : 1;
  localparam int unsigned PW   = SAMPLE_BITS + TAP_W;
  localparam int unsigned SW   = PW + ((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0);

  logic signed [SAMPLE_BITS-1:0] window_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] window_d [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] win_n    [MAX_TAPS];
  logic [LW-1:0] lead_q, lead_d, flush_q, flush_d, c_n;

  logic en, flushing, push, last, emit;
  logic signed [SAMPLE_BITS-1:0] push_s;

  logic signed [PW-1:0] prod_d [MAX_TAPS];
  logic signed [PW-1:0] prod_q [MAX_TAPS];
  logic                 p_vld_q, p_last_q;
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] acc_sh;
  out_t                 out_q;
  logic                 out_vld_q;

  assign c_n = LW'(kern_i.c);

  // Push control: flush pushes take priority over the queue
  always_comb begin
    en       = !out_vld_q || out_ready_i;
    flushing = (flush_q != '0);
    push     = en && (flushing || head_i.vld);
    pop_o    = en && !flushing && head_i.vld;
    push_s   = flushing ? '0 : head_i.item.sample;
    last     = flushing ? (flush_q == LW'(1)) : (head_i.item.frame_end && (c_n == '0));
    emit     = (lead_q >= c_n);
  end

  always_comb begin
    win_n[0] = push_s;
    for (int i = 1; i < MAX_TAPS; i++) begin
      win_n[i] = window_q[i-1];
    end
  end

  always_comb begin
    window_d = window_q;
    lead_d   = lead_q;
    flush_d  = flush_q;
    if (push) begin
      if (flushing) begin
        flush_d = flush_q - LW'(1);
      end else if (head_i.item.frame_end) begin
        flush_d = c_n;
      end
      if (last) begin
        lead_d = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
          window_d[i] = '0;
        end
      end else begin
        window_d = win_n;
        if (!emit) begin
          lead_d = lead_q + LW'(1);
        end
      end
    end
  end

  // Tap products on the shifted window; unused taps give zero
  always_comb begin
    for (int m = 0; m < MAX_TAPS; m++) begin
      if (m < int'(kern_i.k)) begin
        prod_d[m] = win_n[m] * taps_i[m];
      end else begin
        prod_d[m] = '0;
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int m = 0; m < MAX_TAPS; m++) begin
      acc = acc + SW'(prod_q[m]);
    end
    acc_sh = acc >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      flush_q   <= '0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) begin
        window_q[i] <= '0;
      end
    end else begin
      lead_q   <= lead_d;
      flush_q  <= flush_d;
      window_q <= window_d;
      if (en) begin
        p_vld_q   <= push && emit;
        out_vld_q <= p_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q            <= prod_d;
      p_last_q          <= last;
      out_q.result      <= RESULT_W'(acc_sh);
      out_q.result_last <= p_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_i.vld)
    else $error("pop without a queued sample");

  a_no_pop_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_q != '0) |-> !pop_o)
    else $error("queue popped during flush");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && last) |=> (lead_q == '0) && (flush_q == '0))
    else $error("frame state not cleared after last push");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && last) |-> emit)
    else $error("last push of a frame gave no result");
`endif

endmodule

@@ hdl/centered_same_convolution.sv @@
// Top level of the same-mode, zero-padded 1-D convolution block.
// Samples of a frame stream in on the input channel, one transfer each, with
// frame_end on the last one. Each output transfer carries the convolution of
// the frame with the configured kernel (1 to 7 taps, Q4.12), centered at
// c = kernel_size >> 1, as floor(sum >> 12) in 32 bits; samples beyond both
// frame ends count as zero. A frame of N samples gives exactly N results,
// the last one flagged by result_last. Throughput is one sample per cycle
// while the output is not stalled; a frame_end sample holds the back end
// while c zero samples are shifted through the window to flush the lagging
// results. A pushed sample's result passes the product register, then the
// sum and output register, on its way to the output. A two-entry queue
// separates the input from the back end, so the input can still take up to
// two samples while a result waits on the output. Write kernel_size (index 0)
// and tap0..tap6 (index 1..7) only while the block is idle.
module centered_same_convolution #(
  parameter int unsigned MAX_TAPS = csc_pkg::MAX_TAPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [csc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  csc_pkg::in_t                   in_data_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output csc_pkg::out_t                  out_data_o
);
  import csc_pkg::*;

  kern_t                   kern;
  logic signed [TAP_W-1:0] taps [MAX_TAPS];
  head_t                   head;
  logic                    pop;

  // Front: registers, kernel clamp, sample queue
  csc_front #(
    .MAX_TAPS (MAX_TAPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .kern_o     (kern),
    .taps_o     (taps),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: window, flush sequencer, multiply-accumulate, output register
  csc_back #(
    .MAX_TAPS (MAX_TAPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kern_i      (kern),
    .taps_i      (taps),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the same-mode zero-padded convolution block.
`timescale 1ns / 100ps

module tb_top;
  import csc_pkg::*;

  localparam int unsigned MAX_TAPS    = MAX_TAPS_DEF;
  localparam int unsigned RAND_ITEMS  = 155;
  localparam int unsigned DRAIN       = 12;      // pipeline + flush + queue, with margin
  localparam int unsigned HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int unsigned LIMIT       = 200000;  // watchdog, in clock cycles

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;

  centered_same_convolution dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the registers and the sample window.
  // ---------------------------------------------------------------------------
  logic [KS_W-1:0]                kernel_size_q = KERNEL_SIZE_RST;
  logic signed [TAP_W-1:0]        coef_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0]  hist_q [MAX_TAPS];
  int unsigned                    lead_q = 0;

  // Outputs the block still owes us, oldest first.
  out_t due_outputs[$];

  int unsigned n_items, n_frames, n_results, n_writes, n_errors, n_holds;
  int unsigned cycle_cnt;
  bit          hold_req = 1'b0;

  initial begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      coef_q[i] = '0;
      hist_q[i] = '0;
    end
  end

  // Kernel size 0 acts as one tap; anything past the window depth is clamped.
  function automatic int unsigned taps_in_use();
    int unsigned k;
    k = kernel_size_q;
    if (k == 0) k = 1;
    if (k > MAX_TAPS) k = MAX_TAPS;
    return k;
  endfunction

  // Push one sample into the window; emit an output once the lag is covered.
  function automatic void shift_window(logic signed [SAMPLE_BITS-1:0] s, bit last);
    int unsigned     k;
    longint signed   acc;
    out_t            r;
    k   = taps_in_use();
    acc = 0;
    for (int d = MAX_TAPS - 1; d > 0; d--) hist_q[d] = hist_q[d-1];
    hist_q[0] = s;
    if (lead_q < (k >> 1)) begin
      lead_q++;
      return;
    end
    // taps at or past k never contribute
    for (int m = 0; m < k; m++) acc += longint'(coef_q[m]) * longint'(hist_q[m]);
    r.result      = 32'(acc >>> FRAC_BITS);  // floor shift of the exact sum
    r.result_last = last;
    due_outputs.push_back(r);
  endfunction

  function automatic void predict_sample(in_t it);
    int unsigned c;
    c = taps_in_use() >> 1;
    if (!it.frame_end) begin
      shift_window(it.sample, 1'b0);
    end else begin
      // frame end: c zero samples flush the lagging outputs, then clear
      shift_window(it.sample, c == 0);
      for (int unsigned f = 1; f <= c; f++) shift_window('0, f == c);
      for (int i = 0; i < MAX_TAPS; i++) hist_q[i] = '0;
      lead_q = 0;
      n_frames++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver helpers
  // ---------------------------------------------------------------------------
  // Idle = nothing owed and a DRAIN wait for items that produce no output.
  task automatic wait_idle();
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_KERNEL_SIZE) kernel_size_q = data[KS_W-1:0];
    else coef_q[idx - REG_TAP0] = data;
    n_writes++;
  endtask

  // Offer one item and hold it until the transfer; valid stays high on return.
  task automatic send_sample(in_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic idle_gap();
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_tap();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: register writes and samples, some with the output typed in.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_t                   item;
    bit                    typed;
    out_t                  typed_out;
  } dir_step_t;

  dir_step_t dir_steps[$];

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    dir_steps.push_back(s);
  endfunction

  function automatic void add_item(logic signed [SAMPLE_BITS-1:0] smp, bit fend);
    dir_step_t s;
    s = '{default: '0};
    s.item.sample    = smp;
    s.item.frame_end = fend;
    dir_steps.push_back(s);
  endfunction

  // one-output frame whose output is obvious by hand
  function automatic void add_typed(logic signed [SAMPLE_BITS-1:0] smp,
                                    logic signed [RESULT_W-1:0] res);
    add_item(smp, 1'b1);
    dir_steps[$].typed                 = 1'b1;
    dir_steps[$].typed_out.result      = res;
    dir_steps[$].typed_out.result_last = 1'b1;
  endfunction

  function automatic void build_directed();
    // reset state: 3 taps, all zero -> one zero output flagged last
    add_typed(16'sh7FFF, 32'sd0);
    // one tap at the extremes of Q4.12 and of the sample
    add_cfg(REG_KERNEL_SIZE, 16'd1);
    add_cfg(REG_TAP0, 16'h7FFF);
    add_typed(16'sh8000, -32'sd262136);
    add_item(16'sh7FFF, 1'b1);
    add_cfg(REG_TAP0, 16'h8000);
    add_typed(16'sh8000, 32'sd262144);
    add_typed(16'sh7FFF, -32'sd262136);
    // kernel size zero acts as one tap; upper data bits are dropped
    add_cfg(REG_KERNEL_SIZE, 16'hFFF8);
    add_typed(16'sd100, -32'sd800);
    // remaining taps, then a two-tap kernel that must ignore tap2..tap6
    add_cfg(REG_TAP0 + 3'd1, 16'h7FFF);
    add_cfg(REG_TAP0 + 3'd2, 16'h8000);
    add_cfg(REG_TAP0 + 3'd3, 16'h1000);
    add_cfg(REG_TAP0 + 3'd4, 16'h0800);
    add_cfg(REG_TAP0 + 3'd5, 16'hF000);
    add_cfg(REG_TAP0 + 3'd6, 16'h7FFF);
    add_cfg(REG_KERNEL_SIZE, 16'd2);
    add_item(16'sd1000, 1'b0);
    add_item(16'sh8000, 1'b0);
    add_item(16'sh7FFF, 1'b1);
    // full kernel: frame end flushes three outputs
    add_cfg(REG_KERNEL_SIZE, 16'd7);
    add_item(16'sh7FFF, 1'b0);
    add_item(16'sh8000, 1'b0);
    add_item(16'sh7FFF, 1'b0);
    add_item(16'sh8000, 1'b0);
    add_item(16'sd12345, 1'b1);
    // frames shorter than the center offset
    add_item(16'sh8000, 1'b1);
    add_item(16'sd1, 1'b0);
    add_item(-16'sd1, 1'b1);
    // kernel shrinks mid frame
    add_cfg(REG_KERNEL_SIZE, 16'd5);
    add_item(16'sd500, 1'b0);
    add_item(-16'sd700, 1'b0);
    add_item(16'sd900, 1'b0);
    add_cfg(REG_KERNEL_SIZE, 16'd3);
    add_item(16'sd1100, 1'b0);
    add_item(-16'sd1300, 1'b1);
    // kernel grows mid frame
    add_item(16'sd200, 1'b0);
    add_item(16'sd300, 1'b0);
    add_cfg(REG_KERNEL_SIZE, 16'd7);
    add_item(16'sd400, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: checks every output transfer and throttles ready.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    int unsigned steady;
    int unsigned r;
    out_t        want;
    stall  = 0;
    steady = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (due_outputs.size() == 0) begin
          $error("output transfer with nothing due: result=%0d result_last=%0b",
                 out_data_o.result, out_data_o.result_last);
          n_errors++;
        end else begin
          want = due_outputs.pop_front();
          if (out_data_o.result !== want.result) begin
            $error("result: expected %0d, got %0d", want.result, out_data_o.result);
            n_errors++;
          end
          if (out_data_o.result_last !== want.result_last) begin
            $error("result_last: expected %0b, got %0b",
                   want.result_last, out_data_o.result_last);
            n_errors++;
          end
        end
      end
      // long hold-off on request, so the queue fills and input stalls
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
        n_holds++;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (steady > 0) begin
        out_ready_i <= 1'b1;
        steady--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready_i <= 1'b1;
        end else if (r < 70) begin
          out_ready_i <= 1'b1;
          steady = $urandom_range(40, 120);
        end else if (r < 95) begin
          out_ready_i <= 1'b0;
          stall = $urandom_range(0, 2);
        end else begin
          out_ready_i <= 1'b0;
          stall = $urandom_range(15, 50);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_t         it;
    int unsigned n0;
    int unsigned rand_sent;
    int unsigned frame_no;
    int unsigned len;
    bit          no_gaps;
    logic [15:0] ks_word;

    build_directed();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part
    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg) begin
        write_reg(dir_steps[i].idx, dir_steps[i].data);
      end else begin
        send_sample(dir_steps[i].item);
        n0 = due_outputs.size();
        predict_sample(dir_steps[i].item);
        if (dir_steps[i].typed) begin
          // predictor still tracks state, but the hand value is what we check
          while (due_outputs.size() > n0) void'(due_outputs.pop_back());
          due_outputs.push_back(dir_steps[i].typed_out);
        end
        idle_gap();
      end
    end

    // random part: whole frames, reconfigured between frames now and then
    rand_sent = 0;
    frame_no  = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (frame_no > 0 && $urandom_range(0, 2) == 0) begin
        ks_word = 16'($urandom);
        write_reg(REG_KERNEL_SIZE, ks_word);
        for (int t = 0; t < NUM_TAP_REGS; t++)
          if ($urandom_range(0, 2) == 0) write_reg(REG_TAP0 + CFG_IDX_W'(t), rand_tap());
      end
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (frame_no == 4) begin
        // receiver goes quiet while a long gapless frame keeps coming
        hold_req = 1'b1;
        len      = 40;
        no_gaps  = 1'b1;
      end
      for (int unsigned i = 0; i < len; i++) begin
        it.sample    = rand_sample();
        it.frame_end = (i == len - 1);
        send_sample(it);
        predict_sample(it);
        rand_sent++;
        if (!no_gaps) idle_gap();
      end
      frame_no++;
    end

    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (2 * DRAIN) @(posedge clk_i);

    $display("run covered %0d samples in %0d frames, %0d outputs checked",
             n_items, n_frames, n_results);
    $display("%0d register writes, %0d long output hold-offs, %0d mismatches",
             n_writes, n_holds, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ centered_same_convolution.f @@
hdl/csc_pkg.sv
hdl/csc_front.sv
hdl/csc_back.sv
hdl/centered_same_convolution.sv
dv/tb_top.sv
